// ===== hdl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int KIND_W  = 3;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 8;
  localparam int FILL_W  = 9;
  localparam int ERR_W   = 2;

  // Stream packing, lowest bit first.
  localparam int IN_TDATA_W  = 40;   // payload, position
  localparam int OUT_TDATA_W = 112;  // read, head, tail, fill, error, zero pad

  localparam int OUT_READ_LSB = 0;
  localparam int OUT_HEAD_LSB = OUT_READ_LSB + WORD_W;
  localparam int OUT_TAIL_LSB = OUT_HEAD_LSB + WORD_W;
  localparam int OUT_FILL_LSB = OUT_TAIL_LSB + WORD_W;
  localparam int OUT_ERR_LSB  = OUT_FILL_LSB + FILL_W;
  localparam int OUT_USED_W   = OUT_ERR_LSB + ERR_W;

  localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REM_HEAD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REM_TAIL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
  localparam logic [ERR_W-1:0] ERR_INDEX = 2'd3;

  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RSEL_HEAD = 2'd0;
  localparam rd_sel_t RSEL_TAIL = 2'd1;
  localparam rd_sel_t RSEL_IDX  = 2'd2;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic    accept;    // latch the incoming transaction and its error code
    logic    exec;      // apply the operation to pointer, count and store
    logic    rd_en;     // issue a store read
    rd_sel_t rd_sel;    // which logical position the read targets
    logic    cap_head;  // registered read data is the head entry
    logic    cap_tail;  // registered read data is the tail entry
    logic    cap_idx;   // registered read data is the indexed entry
    logic    load_out;  // move the assembled result into the output register
  } bdq_cmd_t;

endpackage

// ===== hdl/bdq_ctrl.sv =====
module bdq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output bdq_pkg::bdq_cmd_t cmd
);
  import bdq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RH   = 3'd2;
  localparam logic [2:0] S_RT   = 3'd3;
  localparam logic [2:0] S_RI   = 3'd4;
  localparam logic [2:0] S_RW   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RSEL_HEAD;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RH;
      end
      S_RH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RSEL_HEAD;
        state_nxt  = S_RT;
      end
      S_RT: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RSEL_TAIL;
        cmd.cap_head = 1'b1;
        state_nxt    = S_RI;
      end
      S_RI: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RSEL_IDX;
        cmd.cap_tail = 1'b1;
        state_nxt    = S_RW;
      end
      S_RW: begin
        cmd.cap_idx = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/bdq_dpath.sv =====
module bdq_dpath #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = bdq_pkg::ELEM_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bdq_pkg::bdq_cmd_t           cmd,
  input  logic [bdq_pkg::KIND_W-1:0]  in_kind,
  input  logic [bdq_pkg::WORD_W-1:0]  in_payload,
  input  logic [bdq_pkg::POS_W-1:0]   in_position,
  output logic [bdq_pkg::WORD_W-1:0]  out_read_word,
  output logic [bdq_pkg::WORD_W-1:0]  out_head_word,
  output logic [bdq_pkg::WORD_W-1:0]  out_tail_word,
  output logic [bdq_pkg::FILL_W-1:0]  out_fill_count,
  output logic [bdq_pkg::ERR_W-1:0]   out_error_code
);
  import bdq_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int XW   = (ELEM_WIDTH > WORD_W) ? ELEM_WIDTH : WORD_W;
  localparam int FXW  = (CW > FILL_W) ? CW : FILL_W;

  logic [ELEM_WIDTH-1:0] mem_r [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_data_r;

  logic [AW-1:0]         head_ptr_r, head_ptr_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [KIND_W-1:0]     kind_r;
  logic [ELEM_WIDTH-1:0] word_r;
  logic [CMPW-1:0]       pos_r;
  logic [ERR_W-1:0]      err_r, err_nxt;

  logic [ELEM_WIDTH-1:0] head_cap_r, tail_cap_r, idx_cap_r;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         head_dec, head_inc;
  logic [CW-1:0]         count_dec;
  logic                  full, empty;
  logic [XW-1:0]         payload_x;

  // Logical position to physical address on the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] to_word(input logic [ELEM_WIDTH-1:0] x);
    logic [XW-1:0] t;
    t = XW'(x);
    return t[WORD_W-1:0];
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign count_dec = count_r - 1'b1;
  assign head_dec  = (head_ptr_r == '0) ? AW'(DEPTH - 1) : head_ptr_r - 1'b1;
  assign head_inc  = (head_ptr_r == AW'(DEPTH - 1)) ? '0 : head_ptr_r + 1'b1;
  assign payload_x = XW'(in_payload);

  // Error code from the state seen at acceptance.
  always_comb begin
    unique case (in_kind) inside
      KIND_INS_HEAD, KIND_INS_TAIL: err_nxt = full ? ERR_FULL : ERR_OK;
      KIND_REM_HEAD, KIND_REM_TAIL: err_nxt = empty ? ERR_EMPTY : ERR_OK;
      KIND_READ: err_nxt = (CMPW'(in_position) < CMPW'(count_r)) ? ERR_OK : ERR_INDEX;
      default:   err_nxt = ERR_INDEX;
    endcase
  end

  always_comb begin
    head_ptr_nxt = head_ptr_r;
    count_nxt    = count_r;
    wr_en        = 1'b0;
    wr_addr      = head_ptr_r;
    if (cmd.exec && (err_r == ERR_OK)) begin
      case (kind_r)
        KIND_INS_HEAD: begin
          head_ptr_nxt = head_dec;
          wr_en        = 1'b1;
          wr_addr      = head_dec;
          count_nxt    = count_r + 1'b1;
        end
        KIND_INS_TAIL: begin
          wr_en     = 1'b1;
          wr_addr   = phys(head_ptr_r, count_r[AW-1:0]);
          count_nxt = count_r + 1'b1;
        end
        KIND_REM_HEAD: begin
          head_ptr_nxt = head_inc;
          count_nxt    = count_dec;
        end
        KIND_REM_TAIL: begin
          count_nxt = count_dec;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RSEL_HEAD: rd_addr = head_ptr_r;
      RSEL_TAIL: rd_addr = phys(head_ptr_r, count_dec[AW-1:0]);
      RSEL_IDX:  rd_addr = phys(head_ptr_r, pos_r[AW-1:0]);
      default:   rd_addr = head_ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= word_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_ptr_r <= '0;
      count_r    <= '0;
    end else begin
      head_ptr_r <= head_ptr_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      word_r <= payload_x[ELEM_WIDTH-1:0];
      pos_r  <= CMPW'(in_position);
      err_r  <= err_nxt;
    end
    if (cmd.cap_head) begin
      head_cap_r <= rd_data_r;
    end
    if (cmd.cap_tail) begin
      tail_cap_r <= rd_data_r;
    end
    if (cmd.cap_idx) begin
      idx_cap_r <= rd_data_r;
    end
  end

  logic [FXW-1:0] fill_x;
  assign fill_x = FXW'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_word  <= ((kind_r == KIND_READ) && (err_r == ERR_OK)) ?
                        to_word(idx_cap_r) : '0;
      out_head_word  <= empty ? '0 : to_word(head_cap_r);
      out_tail_word  <= empty ? '0 : to_word(tail_cap_r);
      out_fill_count <= fill_x[FILL_W-1:0];
      out_error_code <= err_r;
    end
  end

endmodule

// ===== hdl/bounded_array_deque_core.sv =====
// Transactions are handled one at a time: a new one is accepted only after
//   the sequencer has walked the single read port of the entry store (head,
//   tail, indexed read) and loaded the previous result into the output register.
// Reset (rst_n low, synchronous): count, head pointer, sequencer and output
//   valid are cleared; the entry store is not cleared and needs no sweep.
module bounded_array_deque_core #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = bdq_pkg::ELEM_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bdq_pkg::IN_TDATA_W-1:0]   in_tdata,   // payload[31:0], position[39:32]
  input  logic [bdq_pkg::KIND_W-1:0]       in_tuser,   // kind[2:0]
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bdq_pkg::OUT_TDATA_W-1:0]  out_tdata   // read_word[31:0], head_word[63:32],
                                                       // tail_word[95:64], fill_count[104:96],
                                                       // error_code[106:105], zero pad above
);
  import bdq_pkg::*;

  // The deque lives in a ring buffer: a head pointer names the physical slot
  // of logical position zero, so inserting or removing at the head moves the
  // pointer instead of shifting every entry. Logical position i sits at
  // (head + i) modulo DEPTH.

  bdq_cmd_t          cmd;
  logic [WORD_W-1:0] read_word, head_word, tail_word;
  logic [FILL_W-1:0] fill_count;
  logic [ERR_W-1:0]  error_code;

  // The sequencer accepts one transaction, applies it, then reads head, tail
  // and the requested index through the store's read port before handing
  // the result to the output register. A waiting result does not block the
  // next transaction from being accepted and worked on.
  bdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bdq_dpath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_tuser),
    .in_payload     (in_tdata[WORD_W-1:0]),
    .in_position    (in_tdata[WORD_W +: POS_W]),
    .out_read_word  (read_word),
    .out_head_word  (head_word),
    .out_tail_word  (tail_word),
    .out_fill_count (fill_count),
    .out_error_code (error_code)
  );

  // Pack the result fields, lowest first, padded to whole bytes.
  assign out_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                      error_code, fill_count, tail_word, head_word, read_word};

endmodule

// ===== hdl/bdq_checker.sv =====
module bdq_checker #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bdq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bdq_pkg::*;

  logic [FILL_W-1:0] fill;
  logic [ERR_W-1:0]  err;
  logic [WORD_W-1:0] head, tail;

  assign fill = out_tdata[OUT_FILL_LSB +: FILL_W];
  assign err  = out_tdata[OUT_ERR_LSB +: ERR_W];
  assign head = out_tdata[OUT_HEAD_LSB +: WORD_W];
  assign tail = out_tdata[OUT_TAIL_LSB +: WORD_W];

  // No result may survive a reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A full error reports a full store, an empty error an empty one.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && (err == ERR_FULL) |-> (fill == FILL_W'(DEPTH)))
    else $error("full error with store not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && (err == ERR_EMPTY) |-> (fill == '0))
    else $error("empty error with store not empty");

  // An empty store reports zero head and tail words.
  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && (fill == '0) |-> (head == '0) && (tail == '0))
    else $error("empty store shows nonzero head or tail");

endmodule

bind bounded_array_deque_core bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/bounded_array_deque_checker.sv =====
// Watches both stream channels of the deque core. Every accepted input
// transaction is run through a behavioral deque kept here, and the status
// it produces is queued. Every accepted result is compared field by field
// with the oldest queued status.
module bounded_array_deque_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [bdq_pkg::KIND_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bdq_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending_results,
  output logic [bdq_pkg::FILL_W-1:0]      fill_level
);
  import bdq_pkg::*;

  localparam int DEQ_DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic [WORD_W-1:0] head_word;
    logic [WORD_W-1:0] tail_word;
    logic [FILL_W-1:0] fill_count;
    logic [ERR_W-1:0]  error_code;
  } deque_status_t;

  // Element width equals the payload width here, so no bits are dropped.
  logic [WORD_W-1:0] slots [DEQ_DEPTH];
  deque_status_t     status_q [$];

  function automatic deque_status_t apply_deque_op(input logic [KIND_W-1:0] kind,
                                                   input logic [WORD_W-1:0] word,
                                                   input logic [POS_W-1:0]  pos);
    deque_status_t st;
    st = '0;
    case (kind)
      KIND_INS_HEAD: begin
        if (fill_level >= DEQ_DEPTH) begin
          st.error_code = ERR_FULL;
        end else begin
          for (int i = DEQ_DEPTH - 1; i > 0; i--) slots[i] = slots[i-1];
          slots[0] = word;
          fill_level = fill_level + 1'b1;
        end
      end
      KIND_INS_TAIL: begin
        if (fill_level >= DEQ_DEPTH) begin
          st.error_code = ERR_FULL;
        end else begin
          slots[fill_level] = word;
          fill_level = fill_level + 1'b1;
        end
      end
      KIND_REM_HEAD: begin
        if (fill_level == 0) begin
          st.error_code = ERR_EMPTY;
        end else begin
          for (int i = 0; i < DEQ_DEPTH - 1; i++) slots[i] = slots[i+1];
          fill_level = fill_level - 1'b1;
        end
      end
      KIND_REM_TAIL: begin
        if (fill_level == 0) st.error_code = ERR_EMPTY;
        else fill_level = fill_level - 1'b1;
      end
      KIND_READ: begin
        if (pos < fill_level) st.read_word = slots[pos];
        else st.error_code = ERR_INDEX;
      end
      default: begin
        st.error_code = ERR_INDEX;
      end
    endcase
    st.fill_count = fill_level;
    if (fill_level != 0) begin
      st.head_word = slots[0];
      st.tail_word = slots[fill_level - 1'b1];
    end
    return st;
  endfunction

  function automatic bit field_matches(input string name, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    deque_status_t want;
    bit            ok;
    if (!rst_n) begin
      fill_level = '0;
      for (int i = 0; i < DEQ_DEPTH; i++) slots[i] = '0;
      status_q.delete();
    end else begin
      // Inputs first, so a result can never overtake its own expectation.
      if (in_tvalid && in_tready) begin
        status_q.push_back(apply_deque_op(in_tuser, in_tdata[WORD_W-1:0],
                                          in_tdata[WORD_W +: POS_W]));
      end
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          $error("result transaction with no expectation pending: 0x%0h", out_tdata);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          ok = field_matches("read_word", want.read_word,
                             out_tdata[OUT_READ_LSB +: WORD_W]);
          ok &= field_matches("head_word", want.head_word,
                              out_tdata[OUT_HEAD_LSB +: WORD_W]);
          ok &= field_matches("tail_word", want.tail_word,
                              out_tdata[OUT_TAIL_LSB +: WORD_W]);
          ok &= field_matches("fill_count", WORD_W'(want.fill_count),
                              WORD_W'(out_tdata[OUT_FILL_LSB +: FILL_W]));
          ok &= field_matches("error_code", WORD_W'(want.error_code),
                              WORD_W'(out_tdata[OUT_ERR_LSB +: ERR_W]));
          if (!ok) fail_count++;
        end
      end
    end
    pending_results = status_q.size();
  end

endmodule

// ===== bench/bounded_array_deque_core_tb.sv =====
// Top of the deque core bench. This module only makes stimulus and gives the
// verdict; the checker instance beside the core predicts every result and
// counts the failures.
module bounded_array_deque_core_tb;
  import bdq_pkg::*;

  // The quiet time allowed after the last expectation is met, before the verdict.
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_ITEMS    = 1750;
  localparam int QUIET_TAIL      = 150;
  localparam int RUN_LIMIT_UNITS = 2_000_000;

  typedef enum logic [1:0] {
    PH_GROW,
    PH_SHRINK,
    PH_MIX
  } traffic_phase_e;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // payload[31:0], position[39:32]
  logic [KIND_W-1:0]      in_tuser;   // kind[2:0]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // read_word[31:0], head_word[63:32], tail_word[95:64],
                                      // fill_count[104:96], error_code[106:105]

  int               fail_count;
  int               pending_results;
  logic [FILL_W-1:0] fill_level;

  // When set, both sides may idle in random bursts; cleared for quiet
  // stretches and for the final part of the run.
  bit idle_ok;
  int stall_left;
  int issued;

  always #2 clk = ~clk;

  bounded_array_deque_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bounded_array_deque_checker u_deque_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .fill_level      (fill_level)
  );

  // Result side back-pressure, in stall bursts of random length; there is
  // exactly one assignment to out_tready per falling edge.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_ok && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Mostly fully random words, with the all-zero, all-one and single-bit
  // patterns mixed in so both extremes of the payload are hit often.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // Reads mostly target a stored entry, with the last stored entry favored;
  // the rest take the index just past the fill or spread over the whole range.
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (fill_level != 0 && r < 6) return POS_W'($urandom_range(0, fill_level - 1));
    if (fill_level != 0 && r < 8) return POS_W'(fill_level - 1);
    if (r == 8) return POS_W'(fill_level);
    return POS_W'($urandom_range(0, 255));
  endfunction

  // Presents one input transaction at a falling edge and holds it until the
  // core accepts it. A random idle burst may come first. Returns at the
  // falling edge after the accepting rising edge.
  task automatic issue_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word,
                          input logic [POS_W-1:0] pos);
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {pos, word};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    issued++;
  endtask

  // Draws one operation with a mix that depends on the traffic phase. Growing
  // phases push the deque up to full and keep knocking on it; shrinking
  // phases drain it and keep removing from empty.
  task automatic issue_random_op(input traffic_phase_e ph);
    int               r;
    int               ins_lim;
    int               rem_lim;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(0, 99);
    case (ph)
      PH_GROW:   begin ins_lim = 80; rem_lim = 88; end
      PH_SHRINK: begin ins_lim = 12; rem_lim = 80; end
      default:   begin ins_lim = 35; rem_lim = 65; end
    endcase
    if (r < ins_lim) kind = $urandom_range(0, 1) ? KIND_INS_HEAD : KIND_INS_TAIL;
    else if (r < rem_lim) kind = $urandom_range(0, 1) ? KIND_REM_HEAD : KIND_REM_TAIL;
    else if (r < 97) kind = KIND_READ;
    else kind = KIND_W'($urandom_range(5, 7));  // unused kind codes
    issue_op(kind, pick_word(), pick_position());
  endtask

  initial begin
    traffic_phase_e ph;
    int             span;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    idle_ok    = 1'b0;
    stall_left = 0;
    issued     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: removes and a read on an empty deque, inserts at both ends
    // with extreme words, reads inside and past the fill, the unused kind codes,
    // a drain back to empty with one more remove, then an insert, read and remove.
    issue_op(KIND_REM_HEAD, '1, '0);
    issue_op(KIND_REM_TAIL, '0, '1);
    issue_op(KIND_READ, '0, '0);
    issue_op(KIND_INS_TAIL, '0, '1);
    issue_op(KIND_INS_HEAD, '1, '0);
    issue_op(KIND_INS_TAIL, 32'hA5A5_A5A5, 8'h55);
    issue_op(KIND_INS_HEAD, 32'h5A5A_5A5A, 8'hAA);
    issue_op(KIND_READ, '1, 8'd0);
    issue_op(KIND_READ, '0, 8'd3);
    issue_op(KIND_READ, '0, 8'd4);
    issue_op(KIND_READ, '0, 8'd255);
    issue_op(KIND_W'(5), pick_word(), 8'd1);
    issue_op(KIND_W'(6), pick_word(), 8'd2);
    issue_op(KIND_W'(7), '1, '1);
    issue_op(KIND_REM_HEAD, pick_word(), '0);
    issue_op(KIND_REM_TAIL, pick_word(), '0);
    issue_op(KIND_READ, '0, 8'd1);
    issue_op(KIND_REM_HEAD, pick_word(), '0);
    issue_op(KIND_REM_TAIL, pick_word(), '0);
    issue_op(KIND_REM_HEAD, pick_word(), '0);
    issue_op(KIND_INS_HEAD, '1, '0);
    issue_op(KIND_READ, '0, 8'd0);
    issue_op(KIND_REM_TAIL, '0, '0);

    // Random part. The first phase grows the deque from empty to full and the
    // second, of the same length, shrinks it again; after that the phase kind,
    // its length and whether idling is on are all drawn at random.
    issued = 0;
    for (int p = 0; issued < RANDOM_ITEMS; p++) begin
      if (p == 0) begin
        ph = PH_GROW;
        span = 420;
      end else if (p == 1) begin
        ph = PH_SHRINK;
        span = 420;
      end else begin
        ph = traffic_phase_e'($urandom_range(0, 2));
        span = $urandom_range(40, 300);
      end
      idle_ok = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < span && issued < RANDOM_ITEMS; k++) begin
        // The last stretch of the run goes with no idling on either side.
        if (issued >= RANDOM_ITEMS - QUIET_TAIL) idle_ok = 1'b0;
        issue_random_op(ph);
      end
    end

    in_tvalid <= 1'b0;
    idle_ok = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[bounded_array_deque_core] OK");
    end else begin
      $display("[bounded_array_deque_core] ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #RUN_LIMIT_UNITS;
    $display("[bounded_array_deque_core] ERROR");
    $finish;
  end

endmodule
